[hw/rtl/wia_pkg.sv]
// Package: shared constants, operation codes, error codes and sequencer states for the integer ALU.
package wia_pkg;
  localparam int DATA_WIDTH_DEF = 64;

  typedef enum logic [3:0] {
    OP_NEG = 4'd0, OP_NOT = 4'd1, OP_ADD = 4'd2, OP_SUB = 4'd3,
    OP_MUL = 4'd4, OP_DIV = 4'd5, OP_MOD = 4'd6, OP_POW = 4'd7,
    OP_SHL = 4'd8, OP_SAR = 4'd9, OP_SHR = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_DIV = 2'd1, ERR_INVARG = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_POW_ACC, ST_POW_SQR, ST_SHIFT, ST_DONE
  } state_t;
endpackage

[hw/rtl/wia_mulstep.sv]
// Module: shift-add multiplier that runs one operand bit per cycle, low product bits only.
module wia_mulstep #(
  parameter int W = wia_pkg::DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         busy,
  output logic [W-1:0] prod
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  mcand;
  logic [W-1:0]  mplier;
  logic [CW-1:0] cnt;

  assign busy = (cnt != '0);

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= a;
      mplier <= b;
      prod   <= '0;
      cnt    <= CW'(W);
    end else if (busy) begin
      if (mplier[0]) prod <= prod + mcand;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      cnt    <= cnt - 1'b1;
    end
  end
endmodule

[hw/rtl/wrapping_integer_alu_unit.sv]
// Top level: sequenced integer ALU with shared multiplier, bit-serial divider and shifter.
//
//  channel | dir | fields
//  s_axis  | in  | tuser=action, tdata={rhs,lhs}
//  m_axis  | out | tuser=error_code, tdata={result_value,ok}
//
// Neg/not/add/sub and errors go straight from idle to the done state; mul and
// div/mod run serially, shifts move one bit per cycle, and pow runs an
// accumulate and a square multiply per significant exponent bit on the shared
// one-bit-per-cycle multiplier. s_axis_tready is high only in idle.
// The result is held in an output register until m_axis_tready takes it.
// Reset rst is synchronous and clears the sequencer and output valid.
module wrapping_integer_alu_unit #(
  parameter int DATA_WIDTH = wia_pkg::DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // lhs[63:0], rhs[127:64]
  input  logic [3:0]   s_axis_tuser,   // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,   // ok[0], result_value[64:1], zero fill
  output logic [1:0]   m_axis_tuser    // error_code
);
  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W + 1);

  wia_pkg::state_t state, state_next;

  logic [W-1:0]  a, b, acc, aux, res;
  logic [3:0]    op;
  logic [CW-1:0] cnt;
  logic          neg_q, neg_r;
  logic          r_ok;
  logic [1:0]    r_err;
  logic          accept;

  logic          mul_start, mul_busy;
  logic [W-1:0]  mul_a, mul_b, prod;

  // operands of the offered item and their checks
  logic [W-1:0]  in_lhs, in_rhs;
  logic          rhs_zero, shift_bad;
  logic [W-1:0]  ma, mb;

  // values loaded into the datapath when an item is accepted
  logic [W-1:0]  ld_res, ld_acc, ld_aux, ld_b;
  logic          ld_ok;
  logic [1:0]    ld_err;
  logic [CW-1:0] ld_cnt;

  logic          launched;  // a multiply has been started in the current state
  logic          pw_start;
  logic [W-1:0]  pw_a, pw_b;
  logic          pw_done;

  logic          out_load;
  logic [W-1:0]  out_val;
  logic          out_ok;

  // remainder trial subtract for the divider
  logic [W:0]    trial;
  logic [W-1:0]  rem_sh;
  assign rem_sh = {acc[W-2:0], aux[W-1]};
  assign trial  = {acc[W-1], rem_sh} - {1'b0, b};

  assign s_axis_tready = (state == wia_pkg::ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  assign in_lhs    = s_axis_tdata[0 +: W];
  assign in_rhs    = s_axis_tdata[64 +: W];
  assign rhs_zero  = (in_rhs == '0);
  assign shift_bad = in_rhs[W-1] || (in_rhs >= W'(W));
  assign ma = in_lhs[W-1] ? -in_lhs : in_lhs;
  assign mb = in_rhs[W-1] ? -in_rhs : in_rhs;

  wia_mulstep #(.W(W)) u_mul (
    .clk(clk), .start(mul_start), .a(mul_a), .b(mul_b), .busy(mul_busy), .prod(prod)
  );

  // next-state logic
  always_comb begin
    state_next = state;
    case (state)
      wia_pkg::ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            wia_pkg::OP_MUL: state_next = wia_pkg::ST_MUL;
            wia_pkg::OP_DIV, wia_pkg::OP_MOD: begin
              state_next = rhs_zero ? wia_pkg::ST_DONE : wia_pkg::ST_DIV;
            end
            wia_pkg::OP_POW: begin
              state_next = (in_rhs[W-1] || rhs_zero) ? wia_pkg::ST_DONE
                                                     : wia_pkg::ST_POW_ACC;
            end
            wia_pkg::OP_SHL, wia_pkg::OP_SAR, wia_pkg::OP_SHR: begin
              state_next = shift_bad ? wia_pkg::ST_DONE : wia_pkg::ST_SHIFT;
            end
            default: state_next = wia_pkg::ST_DONE;
          endcase
        end
      end
      wia_pkg::ST_MUL:     if (!mul_busy && !mul_start) state_next = wia_pkg::ST_DONE;
      wia_pkg::ST_DIV:     if (cnt == CW'(1)) state_next = wia_pkg::ST_DONE;
      wia_pkg::ST_POW_ACC: if (!mul_busy && !mul_start) state_next = wia_pkg::ST_POW_SQR;
      wia_pkg::ST_POW_SQR: begin
        if (!mul_busy && !mul_start)
          state_next = (b == '0) ? wia_pkg::ST_DONE : wia_pkg::ST_POW_ACC;
      end
      wia_pkg::ST_SHIFT:   if (cnt == '0) state_next = wia_pkg::ST_DONE;
      wia_pkg::ST_DONE:    if (!m_axis_tvalid || m_axis_tready) state_next = wia_pkg::ST_IDLE;
      default:             state_next = wia_pkg::ST_IDLE;
    endcase
  end

  // pow multiplier: acc*base or base*base, launched once on state entry
  assign pw_start = !launched && (state == wia_pkg::ST_POW_ACC || state == wia_pkg::ST_POW_SQR);
  always_comb begin
    pw_a = (state == wia_pkg::ST_POW_ACC) ? acc : a;
    pw_b = a;
  end
  assign pw_done = launched && !mul_busy;

  // multiplier launch control
  always_comb begin
    mul_start = 1'b0;
    mul_a = pw_a;
    mul_b = pw_b;
    case (state)
      wia_pkg::ST_IDLE: begin
        mul_start = accept && (s_axis_tuser == wia_pkg::OP_MUL);
        mul_a = in_lhs;
        mul_b = in_rhs;
      end
      wia_pkg::ST_POW_ACC, wia_pkg::ST_POW_SQR: mul_start = pw_start;
      default: mul_start = 1'b0;
    endcase
  end

  assign out_load = (state == wia_pkg::ST_DONE) && (state_next == wia_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wia_pkg::ST_IDLE;
      m_axis_tvalid <= 1'b0;
      launched <= 1'b0;
    end else begin
      state <= state_next;
      // load a new result, or drop the one just taken
      m_axis_tvalid <= out_load ? 1'b1 : (m_axis_tvalid && !m_axis_tready);
      launched <= (state_next == state) && (state == wia_pkg::ST_POW_ACC ||
                  state == wia_pkg::ST_POW_SQR) ? 1'b1 : 1'b0;
    end
  end

  // load values for an accepted item; quick operations finish here
  always_comb begin
    ld_ok  = 1'b1;
    ld_err = wia_pkg::ERR_NONE;
    ld_res = '0;
    ld_acc = '0;
    ld_aux = '0;
    ld_b   = in_rhs;
    ld_cnt = CW'(W);
    case (s_axis_tuser)
      wia_pkg::OP_NEG: ld_res = -in_lhs;
      wia_pkg::OP_NOT: ld_res = ~in_lhs;
      wia_pkg::OP_ADD: ld_res = in_lhs + in_rhs;
      wia_pkg::OP_SUB: ld_res = in_lhs - in_rhs;
      wia_pkg::OP_MUL: ld_res = '0;
      wia_pkg::OP_DIV, wia_pkg::OP_MOD: begin
        if (rhs_zero) begin
          ld_ok = 1'b0; ld_err = wia_pkg::ERR_DIV;
        end
        ld_aux = ma;
        ld_b   = mb;
      end
      wia_pkg::OP_POW: begin
        ld_acc = W'(1);
        if (in_rhs[W-1]) begin
          if (in_lhs == '0) begin
            ld_ok = 1'b0; ld_err = wia_pkg::ERR_DIV;
          end else if (in_lhs == '1)
            ld_res = in_rhs[0] ? '1 : W'(1);
          else
            ld_res = (in_lhs == W'(1)) ? W'(1) : '0;
        end else ld_res = W'(1);
      end
      wia_pkg::OP_SHL, wia_pkg::OP_SAR, wia_pkg::OP_SHR: begin
        if (shift_bad) begin
          ld_ok = 1'b0; ld_err = wia_pkg::ERR_INVARG;
        end
        ld_res = in_lhs;
        ld_cnt = in_rhs[CW-1:0];
      end
      default: begin
        ld_ok = 1'b0; ld_err = wia_pkg::ERR_INVARG;
      end
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      wia_pkg::ST_IDLE: begin
        if (accept) begin
          op    <= s_axis_tuser;
          a     <= in_lhs;
          b     <= ld_b;
          r_ok  <= ld_ok;
          r_err <= ld_err;
          res   <= ld_res;
          acc   <= ld_acc;
          aux   <= ld_aux;
          cnt   <= ld_cnt;
          neg_q <= in_lhs[W-1] ^ in_rhs[W-1];
          neg_r <= in_lhs[W-1];
        end
      end
      wia_pkg::ST_MUL: if (state_next == wia_pkg::ST_DONE) res <= prod;
      wia_pkg::ST_DIV: begin
        // restoring step: acc is remainder, aux shifts into quotient
        if (!trial[W]) begin
          acc <= trial[W-1:0];
          aux <= {aux[W-2:0], 1'b1};
        end else begin
          acc <= rem_sh;
          aux <= {aux[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          if (op == wia_pkg::OP_DIV) begin
            res <= neg_q ? -{aux[W-2:0], !trial[W]} : {aux[W-2:0], !trial[W]};
          end else begin
            res <= neg_r ? -(trial[W] ? rem_sh : trial[W-1:0])
                         : (trial[W] ? rem_sh : trial[W-1:0]);
          end
        end
      end
      wia_pkg::ST_POW_ACC: if (pw_done) begin
        if (b[0]) acc <= prod;
        b <= b >> 1;
      end
      wia_pkg::ST_POW_SQR: if (pw_done) begin
        a <= prod;
        if (b == '0) res <= acc;
      end
      wia_pkg::ST_SHIFT: begin
        if (cnt != '0) begin
          case (op)
            wia_pkg::OP_SHL: res <= res << 1;
            wia_pkg::OP_SAR: res <= {res[W-1], res[W-1:1]};
            default:         res <= res >> 1;
          endcase
          cnt <= cnt - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register, loaded when leaving the done state
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_val      <= r_ok ? res : '0;
      m_axis_tuser <= r_ok ? wia_pkg::ERR_NONE : r_err;
      out_ok       <= r_ok;
    end
  end
  assign m_axis_tdata = {7'd0, 64'($signed(out_val)), out_ok};
endmodule
